### rtl/core/pdca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdca_pkg
// shared widths, command codes, register indexes and reset values for the
// per-device inflight credit admission block
// ----------------------------------------------------------------------------
package pdca_pkg;

    localparam int NUM_DEVICES_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int DEV_W    = 3;
    localparam int BCNT_W   = 40;
    localparam int BYTES_W  = 48;
    localparam int COPIES_W = 32;
    localparam int DENIAL_W = 64;

    localparam int IN_FIELDS_W = CMD_W + DEV_W + BCNT_W;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + BYTES_W + COPIES_W + DENIAL_W;
    localparam int M_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // one table word holds all three counters of a device
    localparam int ENTRY_W = BYTES_W + COPIES_W + DENIAL_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCHED_ENABLE = 2'd0,
        REG_BYTE_LIMIT   = 2'd1,
        REG_COPY_LIMIT   = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    localparam logic               SCHED_ENABLE_RST = 1'b1;
    localparam logic [BYTES_W-1:0]  BYTE_LIMIT_RST  = 48'd268435456;
    localparam logic [COPIES_W-1:0] COPY_LIMIT_RST  = 32'd4;

    typedef struct packed {
        logic [DENIAL_W-1:0] denials;
        logic [COPIES_W-1:0] copies;
        logic [BYTES_W-1:0]  bytes;
    } entry_t;

endpackage

### rtl/core/pdca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdca_ram
// generic single-clock ram, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module pdca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/per_device_inflight_credit_admission_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_device_inflight_credit_admission_top
// per-device inflight byte and copy credit limiter with denial counting
// ----------------------------------------------------------------------------
// usage
//   requests enter on the s_ channel: acquire, release or query for a device.
//   every request yields exactly one result on the m_ channel: the grant flag
//   and the device's inflight bytes, inflight copies and denial count after
//   the request took effect. a denied acquire is counted, never queued; the
//   requester retries later.
//   limits and the enable are written through the cfg_ port while idle.
// request flow
//   in the idle state a request is taken and the device's counter word is read
//   from the table ram (registered read); in the exec state it is updated and
//   written back once the output register is free. the next request is taken
//   only after the write-back, so no new request enters while one is in flight.
// reset
//   limits return to their defaults; a valid bit per device makes every
//   counter read as zero until the device is first written, so no clearing
//   pass is needed and requests are taken right after reset.
// back-pressure
//   the result sits in an output register. while it is not taken, one more
//   request is read from the table and then waits until the register frees.
// ----------------------------------------------------------------------------
module per_device_inflight_credit_admission_top #(
    parameter int NUM_DEVICES = pdca_pkg::NUM_DEVICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request: cmd[1:0], device[4:2], byte_count[44:5], zero pad above
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pdca_pkg::S_TDATA_W-1:0]    s_tdata,
    // result: granted[0], bytes_inflight[48:1], copies_inflight[80:49],
    // denial_total[144:81], zero pad above
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pdca_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [pdca_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pdca_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import pdca_pkg::*;

    localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // configuration
    logic                sched_enable_reg;
    logic [BYTES_W-1:0]  byte_limit_reg;
    logic [COPIES_W-1:0] copy_limit_reg;

    // request held during the update cycle
    logic [CMD_W-1:0]    cmd_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [BCNT_W-1:0]   bcnt_reg;
    logic                rd_valid_reg;

    state_t              state_reg;
    state_t              state_next;
    logic [NUM_DEVICES-1:0] valid_reg;
    logic [NUM_DEVICES-1:0] valid_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [OUT_FIELDS_W-1:0] result_reg;
    logic [OUT_FIELDS_W-1:0] result_next;

    logic                accept;
    logic                done;
    logic [DEV_W-1:0]    s_device;
    logic [AW-1:0]       s_addr;
    logic [AW-1:0]       x_addr;
    logic                x_in_range;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              cur;
    entry_t              upd;
    logic                wr_en;
    logic                granted;

    logic [BYTES_W:0]    sum;
    logic [BYTES_W-1:0]  bcnt_ext;
    logic [BYTES_W-1:0]  cap;
    logic                bytes_ok;
    logic                copies_ok;

    assign s_device = s_tdata[CMD_W +: DEV_W];
    assign s_addr   = AW'(s_device);
    assign x_addr   = AW'(dev_reg);
    assign x_in_range = 32'(dev_reg) < 32'(NUM_DEVICES);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // update may proceed when the output register is free or being emptied
    assign done     = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_enable_reg <= SCHED_ENABLE_RST;
            byte_limit_reg   <= BYTE_LIMIT_RST;
            copy_limit_reg   <= COPY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SCHED_ENABLE: sched_enable_reg <= cfg_data[0];
                REG_BYTE_LIMIT:   byte_limit_reg   <= cfg_data[BYTES_W-1:0];
                REG_COPY_LIMIT:   copy_limit_reg   <= cfg_data[COPIES_W-1:0];
                default:          ;
            endcase
        end
    end

    // request capture, ram read issued in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= s_tdata[CMD_W-1:0];
            dev_reg      <= s_device;
            bcnt_reg     <= s_tdata[CMD_W+DEV_W +: BCNT_W];
            rd_valid_reg <= valid_reg[s_addr];
        end
    end

    pdca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_DEVICES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (x_addr),
        .wdata (upd),
        .re    (accept),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    // never-written devices read as zero
    assign cur = rd_valid_reg ? entry_t'(ram_rdata) : '0;

    // admission check
    assign bcnt_ext  = BYTES_W'(bcnt_reg);
    assign sum       = {1'b0, cur.bytes} + {1'b0, bcnt_ext};
    assign cap       = (byte_limit_reg > bcnt_ext) ? byte_limit_reg : bcnt_ext;
    assign bytes_ok  = (byte_limit_reg == '0) || (sum <= {1'b0, cap});
    assign copies_ok = (copy_limit_reg == '0) || (cur.copies < copy_limit_reg);

    always_comb
    begin
        upd     = cur;
        granted = 1'b0;
        wr_en   = 1'b0;
        case (cmd_t'(cmd_reg))
            CMD_ACQUIRE:
            begin
                if (!sched_enable_reg)
                begin
                    granted = 1'b1;
                end
                else if (bytes_ok && copies_ok)
                begin
                    granted   = 1'b1;
                    wr_en     = done && x_in_range;
                    upd.bytes = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                    if (cur.copies != '1)
                    begin
                        upd.copies = cur.copies + 1'b1;
                    end
                end
                else
                begin
                    wr_en = done && x_in_range;
                    if (cur.denials != '1)
                    begin
                        upd.denials = cur.denials + 1'b1;
                    end
                end
            end
            CMD_RELEASE:
            begin
                wr_en     = done && x_in_range;
                upd.bytes = (cur.bytes >= bcnt_ext) ? (cur.bytes - bcnt_ext) : '0;
                if (cur.copies != '0)
                begin
                    upd.copies = cur.copies - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // fsm, valid bits and output register
    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg;
        result_next   = result_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    if (x_in_range)
                    begin
                        result_next = {upd.denials, upd.copies, upd.bytes, granted};
                    end
                    else
                    begin
                        result_next = '0;
                    end
                    if (wr_en)
                    begin
                        valid_next[x_addr] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            result_reg   <= result_next;
        end
    end

endmodule

### tb/tb_per_device_inflight_credit_admission_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_device_inflight_credit_admission_top
// self-checking bench for the per-device inflight credit admission block.
// requests (acquire, release, query, reserved code) go in on the s_ stream.
// a credit predictor follows each accepted request, and every result on the
// m_ stream is compared field by field in order. limits and the enable are
// rewritten between phases once the block is drained. both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_per_device_inflight_credit_admission_top;

    import pdca_pkg::*;

    localparam int NDEV        = NUM_DEVICES_DEF;
    localparam int STALL_LIMIT = 2000;

    localparam logic [BCNT_W-1:0]  BCNT_MAX  = {BCNT_W{1'b1}};
    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
    localparam logic [COPIES_W-1:0] COPIES_MAX = {COPIES_W{1'b1}};

    // result word as it sits in m_tdata, granted in bit 0
    typedef struct packed {
        logic [DENIAL_W-1:0] denial_total;
        logic [COPIES_W-1:0] copies_inflight;
        logic [BYTES_W-1:0]  bytes_inflight;
        logic                granted;
    } credit_result_t;

    // ------------------------------------------------------------------------
    // credit predictor and in-order result checker
    // ------------------------------------------------------------------------
    class credit_scoreboard;
        logic                sched_on;
        logic [BYTES_W-1:0]  byte_cap;
        logic [COPIES_W-1:0] copy_cap;
        logic [BYTES_W-1:0]  bytes_used [NDEV];
        logic [COPIES_W-1:0] copies_used [NDEV];
        logic [DENIAL_W-1:0] denials [NDEV];
        credit_result_t      pending_results [$];
        int                  errors;

        function new();
            sched_on = SCHED_ENABLE_RST;
            byte_cap = BYTE_LIMIT_RST;
            copy_cap = COPY_LIMIT_RST;
            errors   = 0;
            for (int d = 0; d < NDEV; d++)
            begin
                bytes_used[d]  = '0;
                copies_used[d] = '0;
                denials[d]     = '0;
            end
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SCHED_ENABLE: sched_on = value[0];
                REG_BYTE_LIMIT:   byte_cap = value[BYTES_W-1:0];
                REG_COPY_LIMIT:   copy_cap = value[COPIES_W-1:0];
                default: ;
            endcase
        endfunction

        // both limits must allow it; an oversize copy fits an empty device
        function bit admits(int d, logic [BCNT_W-1:0] bc);
            logic [BYTES_W:0]   total;
            logic [BYTES_W-1:0] cap;
            bit                 bytes_ok;
            bit                 copies_ok;
            total     = {1'b0, bytes_used[d]} + (BYTES_W+1)'(bc);
            cap       = (byte_cap > BYTES_W'(bc)) ? byte_cap : BYTES_W'(bc);
            bytes_ok  = (byte_cap == '0) || (total <= {1'b0, cap});
            copies_ok = (copy_cap == '0) || (copies_used[d] < copy_cap);
            return bytes_ok && copies_ok;
        endfunction

        function void note_request(cmd_t cmd, logic [DEV_W-1:0] dev,
                                   logic [BCNT_W-1:0] bc);
            credit_result_t   r;
            logic [BYTES_W:0] total;
            int               d;
            d = dev;
            r = '0;
            if (d < NDEV)
            begin
                case (cmd)
                    CMD_ACQUIRE:
                    begin
                        if (!sched_on)
                            r.granted = 1'b1;
                        else if (admits(d, bc))
                        begin
                            total = {1'b0, bytes_used[d]} + (BYTES_W+1)'(bc);
                            bytes_used[d] = total[BYTES_W] ? BYTES_MAX
                                                           : total[BYTES_W-1:0];
                            if (copies_used[d] != COPIES_MAX)
                                copies_used[d] = copies_used[d] + 1'b1;
                            r.granted = 1'b1;
                        end
                        else if (denials[d] != {DENIAL_W{1'b1}})
                            denials[d] = denials[d] + 1'b1;
                    end
                    CMD_RELEASE:
                    begin
                        if (bytes_used[d] >= BYTES_W'(bc))
                            bytes_used[d] = bytes_used[d] - BYTES_W'(bc);
                        else
                            bytes_used[d] = '0;
                        if (copies_used[d] != '0)
                            copies_used[d] = copies_used[d] - 1'b1;
                    end
                    default: ;
                endcase
                r.bytes_inflight  = bytes_used[d];
                r.copies_inflight = copies_used[d];
                r.denial_total    = denials[d];
            end
            pending_results = {pending_results, r};
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            credit_result_t got;
            credit_result_t want;
            got = data[OUT_FIELDS_W-1:0];
            if (pending_results.size() == 0)
            begin
                if (errors < 10)
                    $display("%0t: result with no request outstanding: %h", $realtime, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.granted !== want.granted
                || got.bytes_inflight !== want.bytes_inflight
                || got.copies_inflight !== want.copies_inflight
                || got.denial_total !== want.denial_total)
            begin
                if (errors < 10)
                    $display("%0t: mismatch granted %b/%b bytes %h/%h copies %h/%h denials %h/%h",
                             $realtime, want.granted, got.granted,
                             want.bytes_inflight, got.bytes_inflight,
                             want.copies_inflight, got.copies_inflight,
                             want.denial_total, got.denial_total);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // request: cmd, device, byte_count, zero pad above
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // result: granted, bytes_inflight, copies_inflight, denial_total, zero pad
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    credit_scoreboard sb;
    bit               calm;      // no idling on either side while set
    int               quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    per_device_inflight_credit_admission_top #(
        .NUM_DEVICES(NDEV)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 34);
    endfunction

    function automatic logic [BCNT_W-1:0] rand_bcnt();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[BCNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // result side: stall at random, check every accepted result
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        sb = new();
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            @(negedge clk);
            m_tready <= !idle_now();
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    task automatic send_request(cmd_t cmd, logic [DEV_W-1:0] dev,
                                logic [BCNT_W-1:0] bc);
        while (idle_now())
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({bc, dev, cmd});
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, dev, bc);
    endtask

    // wait until every result is back, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // register writes, one per cycle, only with the block drained
    task automatic write_regs(logic en, logic [BYTES_W-1:0] blim,
                              logic [COPIES_W-1:0] clim);
        reg_index_t       idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = REG_SCHED_ENABLE; val[0] = CFG_DATA_W'(en);
        idx[1] = REG_BYTE_LIMIT;   val[1] = CFG_DATA_W'(blim);
        idx[2] = REG_COPY_LIMIT;   val[2] = CFG_DATA_W'(clim);
        for (int i = 0; i < 3; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            sb.set_reg(idx[i], val[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_one(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // request size: small, scaled to the byte limit, what the device holds,
    // fully random, or an extreme
    function automatic logic [BCNT_W-1:0] pick_size(int d);
        logic [63:0] lim;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return BCNT_W'($urandom_range(0, 255));
        if (r < 50)
        begin
            lim = 64'(sb.byte_cap);
            if (lim == 0 || lim > 64'(BCNT_MAX))
                lim = 64'h1_0000_0000;
            return BCNT_W'(64'(rand_bcnt()) % ((lim >> 1) + 1));
        end
        if (r < 65)
            return (sb.bytes_used[d] > BYTES_W'(BCNT_MAX))
                   ? BCNT_MAX : sb.bytes_used[d][BCNT_W-1:0];
        if (r < 80)
            return rand_bcnt();
        if (r < 90)
            return BCNT_MAX;
        return '0;
    endfunction

    // heavy mode piles maximum-size acquires on one device to saturate it
    task automatic random_requests(int count, bit heavy);
        int   r;
        int   d;
        cmd_t cmd;
        for (int i = 0; i < count; i++)
        begin
            if (heavy && $urandom_range(0, 99) < 80)
                send_request(CMD_ACQUIRE, 3'd2, BCNT_MAX);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    cmd = CMD_ACQUIRE;
                else if (r < 80)
                    cmd = CMD_RELEASE;
                else if (r < 95)
                    cmd = CMD_QUERY;
                else
                    cmd = CMD_RSVD;
                d = $urandom_range(0, NDEV - 1);
                send_request(cmd, DEV_W'(d), pick_size(d));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_SCHED_ENABLE;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part with the reset limits: 256 MiB, 4 copies
        send_request(CMD_QUERY,   3'd0, BCNT_MAX);
        send_request(CMD_ACQUIRE, 3'd0, BCNT_MAX);            // oversize on empty device
        send_request(CMD_ACQUIRE, 3'd0, '0);                  // denied on bytes
        send_request(CMD_RSVD,    3'd0, '0);                  // reserved code reads like a query
        send_request(CMD_RELEASE, 3'd0, 40'd1);
        send_request(CMD_RELEASE, 3'd0, BCNT_MAX);            // bytes floor at zero
        send_request(CMD_RELEASE, 3'd0, BCNT_MAX);            // copies floor at zero
        repeat (4) send_request(CMD_ACQUIRE, 3'd7, 40'h400_0000);
        send_request(CMD_ACQUIRE, 3'd7, '0);                  // denied on copy limit
        send_request(CMD_RELEASE, 3'd7, 40'h400_0000);
        send_request(CMD_ACQUIRE, 3'd7, 40'h400_0001);        // one byte over the limit
        send_request(CMD_ACQUIRE, 3'd7, 40'h400_0000);        // exactly at the limit
        send_request(CMD_QUERY,   3'd7, '0);
        drain();

        // disabled: every acquire granted, nothing charged; release still counts
        write_one(REG_SCHED_ENABLE, '0);
        send_request(CMD_ACQUIRE, 3'd5, BCNT_MAX);
        send_request(CMD_ACQUIRE, 3'd7, 40'd1);
        send_request(CMD_RELEASE, 3'd7, '0);
        drain();

        // unused register index must leave the settings alone
        write_one(REG_NONE, {CFG_DATA_W{1'b1}});
        write_one(REG_SCHED_ENABLE, 48'd1);
        send_request(CMD_ACQUIRE, 3'd3, 40'hAA_AAAA_AAAA);
        send_request(CMD_RELEASE, 3'd3, 40'h55_5555_5555);
        send_request(CMD_QUERY,   3'd3, '0);
        drain();

        // random phases over several settings, extremes among them
        write_regs(SCHED_ENABLE_RST, BYTE_LIMIT_RST, COPY_LIMIT_RST);
        random_requests(400, 1'b0);
        drain();
        write_regs(1'b1, 48'd4096, 32'd2);
        random_requests(400, 1'b0);
        drain();
        write_regs(1'b0, 48'd4096, 32'd2);
        random_requests(200, 1'b0);
        drain();
        // unlimited: drives one device's inflight bytes into saturation
        write_regs(1'b1, '0, '0);
        random_requests(400, 1'b1);
        drain();
        // largest limits, run back to back with no idling on either side
        write_regs(1'b1, BYTES_MAX, COPIES_MAX);
        calm = 1'b1;
        random_requests(250, 1'b0);
        drain();
        calm = 1'b0;
        write_regs(1'b1, 48'd1, 32'd1);
        random_requests(300, 1'b0);
        drain();

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
